/* rtl/lsra_pkg.sv */
// Shared types and constants for the linear-scan register allocator.
`default_nettype none
package lsra_pkg;

    localparam int POOL_SIZE     = 4;
    localparam int POOL_IDX_BITS = 2;
    localparam int COUNT_BITS    = 3;
    localparam int VID_BITS      = 12;
    localparam int POS_BITS      = 16;
    localparam int HOME_BITS     = 24;
    localparam int SLOT_CNT_BITS = 25;

    localparam logic [COUNT_BITS-1:0]    POOL_COUNT = 3'd4;
    localparam logic [HOME_BITS-1:0]     REG_BASE   = 24'd12;
    localparam logic [SLOT_CNT_BITS-1:0] SLOT_LIMIT = 25'h100_0000;

    // Configuration register indexes.
    localparam int REG_ALLOC_DISABLE = 0;

    typedef struct packed {
        logic                new_function;
        logic [VID_BITS-1:0] value_id;
        logic                defined;
        logic                is_integer;
        logic                spans_call;
        logic [POS_BITS-1:0] start_pos;
        logic [POS_BITS-1:0] end_pos;
    } in_item_t;

    typedef struct packed {
        logic [VID_BITS-1:0]      result_value_id;
        logic                     home_is_slot;
        logic [HOME_BITS-1:0]     home_index;
        logic                     evicted;
        logic [VID_BITS-1:0]      evicted_value_id;
        logic [HOME_BITS-1:0]     evicted_slot;
        logic                     status;
        logic [SLOT_CNT_BITS-1:0] slots_used;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
        logic best;
        logic place_slot;
        logic place_alloc;
        logic place_evict;
    } lsra_cmd_t;

    typedef struct packed {
        logic out_free;
        logic defined;
        logic dead;
        logic more;
        logic can_alloc;
        logic can_evict;
    } lsra_status_t;

endpackage
`default_nettype wire

/* rtl/lsra_datapath.sv */
// Datapath of the allocator: active list, busy bits, slot counter and result register.
`default_nettype none
module lsra_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  alloc_disable,
    input  wire lsra_pkg::in_item_t    in_data,
    input  wire lsra_pkg::lsra_cmd_t   cmd,
    output lsra_pkg::lsra_status_t     stat,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output lsra_pkg::out_item_t        out_data
);
    import lsra_pkg::*;

    in_item_t                 item_reg, item_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [COUNT_BITS-1:0]    cursor_reg, cursor_next;
    logic [VID_BITS-1:0]      val_reg [POOL_SIZE];
    logic [VID_BITS-1:0]      val_next [POOL_SIZE];
    logic [POS_BITS-1:0]      end_reg [POOL_SIZE];
    logic [POS_BITS-1:0]      end_next [POOL_SIZE];
    logic [POOL_IDX_BITS-1:0] pslot_reg [POOL_SIZE];
    logic [POOL_IDX_BITS-1:0] pslot_next [POOL_SIZE];
    logic [POOL_SIZE-1:0]     busy_reg, busy_next;
    logic [SLOT_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     err_reg, err_next;
    logic [POOL_IDX_BITS-1:0] best_idx_reg, best_idx_next;
    logic [POS_BITS-1:0]      best_end_reg, best_end_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_reg, out_next;

    logic [POOL_IDX_BITS-1:0] cur_idx, last_idx, cnt_idx, free_idx, scan_idx;
    logic [COUNT_BITS-1:0]    count_dec;
    logic [POS_BITS-1:0]      scan_end;
    logic                     has_free, retire_hit, slot_ok, evict_win, place;

    assign cur_idx    = cursor_reg[POOL_IDX_BITS-1:0];
    assign count_dec  = count_reg - 1'b1;
    assign last_idx   = count_dec[POOL_IDX_BITS-1:0];
    assign cnt_idx    = count_reg[POOL_IDX_BITS-1:0];
    assign retire_hit = end_reg[cur_idx] < item_reg.start_pos;
    assign slot_ok    = cnt_reg < SLOT_LIMIT;
    assign evict_win  = best_end_reg > item_reg.end_pos;
    assign place      = cmd.place_slot | cmd.place_alloc | cmd.place_evict;

    // Lowest free register of the pool.
    always_comb
    begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                has_free = 1'b1;
                free_idx = POOL_IDX_BITS'(i);
            end
        end
    end

    // Latest end among the live entries; the first maximum wins.
    always_comb
    begin
        scan_idx = '0;
        scan_end = end_reg[0];
        for (int k = 1; k < POOL_SIZE; k++)
        begin
            if ((COUNT_BITS'(k) < count_reg) && (end_reg[k] > scan_end))
            begin
                scan_idx = POOL_IDX_BITS'(k);
                scan_end = end_reg[k];
            end
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.defined   = item_reg.defined;
    assign stat.dead      = !item_reg.is_integer || item_reg.spans_call ||
                            (item_reg.end_pos <= item_reg.start_pos);
    assign stat.more      = cursor_reg < count_reg;
    assign stat.can_alloc = !alloc_disable && has_free && (count_reg < POOL_COUNT);
    assign stat.can_evict = !alloc_disable && (count_reg != '0);

    always_comb
    begin
        item_next     = item_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        val_next      = val_reg;
        end_next      = end_reg;
        pslot_next    = pslot_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        best_idx_next = best_idx_reg;
        best_end_next = best_end_reg;
        out_next      = out_reg;

        if (cmd.load)
        begin
            item_next   = in_data;
            cursor_next = '0;
            if (in_data.new_function)
            begin
                count_next = '0;
                busy_next  = '0;
                cnt_next   = '0;
                err_next   = 1'b0;
            end
        end

        // One swap-remove step of retirement.
        if (cmd.step)
        begin
            if (retire_hit)
            begin
                busy_next[pslot_reg[cur_idx]] = 1'b0;
                count_next                    = count_dec;
                val_next[cur_idx]             = val_reg[last_idx];
                end_next[cur_idx]             = end_reg[last_idx];
                pslot_next[cur_idx]           = pslot_reg[last_idx];
            end
            else
            begin
                cursor_next = cursor_reg + 1'b1;
            end
        end

        if (cmd.best)
        begin
            best_idx_next = scan_idx;
            best_end_next = scan_end;
        end

        if (place)
        begin
            out_next                  = '0;
            out_next.result_value_id  = item_reg.value_id;
            out_next.home_is_slot     = 1'b1;
            if (cmd.place_alloc)
            begin
                busy_next[free_idx]   = 1'b1;
                val_next[cnt_idx]     = item_reg.value_id;
                end_next[cnt_idx]     = item_reg.end_pos;
                pslot_next[cnt_idx]   = free_idx;
                count_next            = count_reg + 1'b1;
                out_next.home_is_slot = 1'b0;
                out_next.home_index   = REG_BASE + HOME_BITS'(free_idx);
            end
            else if (cmd.place_evict && evict_win && slot_ok)
            begin
                out_next.evicted          = 1'b1;
                out_next.evicted_value_id = val_reg[best_idx_reg];
                out_next.evicted_slot     = cnt_reg[HOME_BITS-1:0];
                cnt_next                  = cnt_reg + 1'b1;
                val_next[best_idx_reg]    = item_reg.value_id;
                end_next[best_idx_reg]    = item_reg.end_pos;
                out_next.home_is_slot     = 1'b0;
                out_next.home_index       = REG_BASE + HOME_BITS'(pslot_reg[best_idx_reg]);
            end
            else if (slot_ok)
            begin
                out_next.home_index = cnt_reg[HOME_BITS-1:0];
                cnt_next            = cnt_reg + 1'b1;
            end
            else
            begin
                err_next = 1'b1;
            end
            out_next.status     = err_next;
            out_next.slots_used = cnt_next;
        end
    end

    assign out_valid_next = place || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            busy_reg      <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        val_reg      <= val_next;
        end_reg      <= end_next;
        pslot_reg    <= pslot_next;
        best_idx_reg <= best_idx_next;
        best_end_reg <= best_end_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

/* rtl/lsra_controller.sv */
// Sequencing state machine of the allocator.
`default_nettype none
module lsra_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire lsra_pkg::lsra_status_t stat,
    output lsra_pkg::lsra_cmd_t         cmd
);
    import lsra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RETIRE,
        S_BEST,
        S_SLOT,
        S_ALLOC,
        S_EVICT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RETIRE;
                end
            end
            S_RETIRE:
            begin
                priority if (!stat.defined)
                    state_next = S_SLOT;
                else if (stat.more)
                    cmd.step = 1'b1;
                else if (stat.dead)
                    state_next = S_SLOT;
                else if (stat.can_alloc)
                    state_next = S_ALLOC;
                else if (stat.can_evict)
                    state_next = S_BEST;
                else
                    state_next = S_SLOT;
            end
            S_BEST:
            begin
                cmd.best   = 1'b1;
                state_next = S_EVICT;
            end
            S_SLOT:
            begin
                if (stat.out_free)
                begin
                    cmd.place_slot = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ALLOC:
            begin
                if (stat.out_free)
                begin
                    cmd.place_alloc = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EVICT:
            begin
                if (stat.out_free)
                begin
                    cmd.place_evict = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* rtl/linear_scan_register_allocator_top.sv */
// Top level of the linear-scan register allocator with its configuration port.
// A result beat is offered once its item has been placed; for a defined value placement
// follows a retirement walk that examines each active entry in swap-remove order, an
// eviction first picks the entry with the latest end, and placement waits on a stalled result.
// A new item is taken only when idle, after the previous item has been placed.
// Reset clears the active list, busy bits, slot counter, error and alloc_disable at once.
`default_nettype none
module linear_scan_register_allocator_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lsra_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lsra_pkg::out_item_t     out_data
);
    import lsra_pkg::*;

    logic         alloc_disable_reg, alloc_disable_next;
    logic         reg_sel;
    lsra_cmd_t    cmd;
    lsra_status_t stat;

    // The single register sits at byte address zero; the upper address bit selects
    // nothing, so writes there are dropped and reads return zero.
    assign reg_sel = (paddr[2] == 1'(REG_ALLOC_DISABLE));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'd0, alloc_disable_reg} : 32'd0;

    always_comb
    begin
        alloc_disable_next = alloc_disable_reg;
        if (psel && penable && pwrite && reg_sel)
            alloc_disable_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alloc_disable_reg <= 1'b0;
        else
            alloc_disable_reg <= alloc_disable_next;
    end

    // The controller walks each item through retirement, the choice of home and the
    // placement; the datapath holds every piece of allocator state.
    lsra_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath's result register decouples the output beat from the next item, so
    // a new item may be accepted while an earlier result still waits.
    lsra_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .alloc_disable (alloc_disable_reg),
        .in_data       (in_data),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_data      (out_data)
    );

endmodule
`default_nettype wire

/* rtl/lsra_checker.sv */
// Port-level checker for the allocator and its bind to the top level.
`default_nettype none
module lsra_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire lsra_pkg::out_item_t out_data
);
    import lsra_pkg::*;

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on back-to-back cycles");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // A register home always lies in the pool's register numbers.
    a_reg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.home_is_slot |->
            (out_data.home_index >= REG_BASE) &&
            (out_data.home_index < REG_BASE + HOME_BITS'(POOL_SIZE)))
        else $error("register home outside the pool");

    // An eviction always hands the freed register to the new value.
    a_evict_reg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.evicted |-> !out_data.home_is_slot)
        else $error("eviction without a register home");

    // The slot counter never runs past the limit.
    a_slot_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.slots_used <= SLOT_LIMIT)
        else $error("slot counter past limit");

endmodule

bind linear_scan_register_allocator_top lsra_checker u_lsra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
